FILE: src/rbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and defaults for the ring buffer deque: operation codes,
// status codes and the slot store command.
// ----------------------------------------------------------------------------
package rbd_pkg;

   // Default geometry
   localparam int unsigned DepthDefault     = 16;
   localparam int unsigned DataWidthDefault = 32;

   // Operation requested by one input word
   typedef enum logic [2:0] {
      MODE_PUSH_BACK  = 3'd0,
      MODE_PUSH_FRONT = 3'd1,
      MODE_POP_BACK   = 3'd2,
      MODE_POP_FRONT  = 3'd3,
      MODE_CLEAR      = 3'd4
   } mode_type;

   // Completion status returned with every result word
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Access strobes for the slot store
   typedef struct packed {
      logic wr;
      logic rd;
   } ram_cmd_type;

endpackage

FILE: src/rbd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_ram
// Single-port slot store with one write or one read per cycle; read data is
// registered and holds until the next read.
// ----------------------------------------------------------------------------
module rbd_ram #(
   parameter int unsigned DEPTH      = rbd_pkg::DepthDefault,
   parameter int unsigned DATA_WIDTH = rbd_pkg::DataWidthDefault
) (
   input  logic                         clock,
   input  rbd_pkg::ram_cmd_type         cmd,
   input  logic [$clog2(DEPTH)-1:0]     addr,
   input  logic [DATA_WIDTH-1:0]        wr_data,
   output logic [DATA_WIDTH-1:0]        rd_data
);
   import rbd_pkg::*;

   logic [DATA_WIDTH-1:0] ram_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // Write the addressed slot
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         ram_ff[addr] <= wr_data;
      end
   end

   // Read the addressed slot; hold the last read otherwise
   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_data_ff <= ram_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ring_buffer_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_deque
// Fixed-capacity double-ended queue kept in a circular slot store.
// ----------------------------------------------------------------------------
// The block takes one operation word per cycle (push back, push front, pop
// back, pop front, clear) and returns one result word for each, in the cycle
// after acceptance, through a single output register. A new word is taken
// when that register is empty or when its result is accepted in the same
// cycle, so the input stalls only while the result side holds off a waiting
// result. Pointers and the fill count update in the accept cycle; the
// single-port slot store does the one write or one read of the operation in
// that same cycle, and its registered read data feeds the result. Pushes to
// a full queue return the full status, pops from an empty queue the empty
// status; neither changes any state. Clear zeroes the count and keeps both
// pointers. The store needs no initialization pass after reset.
// ----------------------------------------------------------------------------
module ring_buffer_deque #(
   parameter int unsigned DEPTH      = rbd_pkg::DepthDefault,
   parameter int unsigned DATA_WIDTH = rbd_pkg::DataWidthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rbd_pkg::mode_type             req_mode,
   input  logic [DATA_WIDTH-1:0]         req_push_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [DATA_WIDTH-1:0]         rsp_pop_value,
   output rbd_pkg::status_type           rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]    rsp_count
);
   import rbd_pkg::*;

   localparam int unsigned PtrWidth = $clog2(DEPTH);
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(DEPTH);

   logic [PtrWidth-1:0] head_ff, head_in;
   logic [PtrWidth-1:0] tail_ff, tail_in;
   logic [CntWidth-1:0] count_ff, count_in;

   logic                rsp_valid_ff;
   logic                pop_ok_ff, pop_ok_in;
   status_type          status_ff, status_in;
   logic [CntWidth-1:0] rsp_count_ff;

   logic                accept;
   ram_cmd_type         ram_cmd;
   logic [PtrWidth-1:0] ram_addr;
   logic [DATA_WIDTH-1:0] ram_rd_data;

   logic [PtrWidth-1:0] head_inc, head_dec, tail_inc, tail_dec;
   logic                is_full, is_empty;

   // Take a new word whenever the output register is free or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Wrapped pointer neighbors
   assign head_inc = (head_ff == PtrLast) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? PtrLast : head_ff - 1'b1;
   assign tail_inc = (tail_ff == PtrLast) ? '0 : tail_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? PtrLast : tail_ff - 1'b1;
   assign is_full  = (count_ff == CntFull);
   assign is_empty = (count_ff == '0);

   // Decode the operation: next pointers, count, status and store access
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      status_in = STATUS_OK;
      pop_ok_in = 1'b0;
      ram_addr  = tail_ff;
      ram_cmd   = '0;
      unique case (req_mode)
         MODE_PUSH_BACK: begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               ram_addr   = tail_ff;
               ram_cmd.wr = accept;
               tail_in    = tail_inc;
               count_in   = count_ff + 1'b1;
            end
         end
         MODE_PUSH_FRONT: begin
            if (is_full) begin
               status_in = STATUS_FULL;
            end else begin
               ram_addr   = head_dec;
               ram_cmd.wr = accept;
               head_in    = head_dec;
               count_in   = count_ff + 1'b1;
            end
         end
         MODE_POP_BACK: begin
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               ram_addr   = tail_dec;
               ram_cmd.rd = accept;
               tail_in    = tail_dec;
               count_in   = count_ff - 1'b1;
               pop_ok_in  = 1'b1;
            end
         end
         MODE_POP_FRONT: begin
            if (is_empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               ram_addr   = head_ff;
               ram_cmd.rd = accept;
               head_in    = head_inc;
               count_in   = count_ff - 1'b1;
               pop_ok_in  = 1'b1;
            end
         end
         MODE_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Advance the queue state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Output register: valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register: result fields, hold while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         pop_ok_ff    <= pop_ok_in;
         status_ff    <= status_in;
         rsp_count_ff <= count_in;
      end
   end

   rbd_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .addr    (ram_addr),
      .wr_data (req_push_value),
      .rd_data (ram_rd_data)
   );

   // Drop read data for anything but a successful pop
   assign rsp_pop_value = pop_ok_ff ? ram_rd_data : '0;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_count     = rsp_count_ff;

endmodule
